[hw/rtl/kmd_pkg.sv]
// shared constants for the key matrix debounce block
`timescale 1ns / 1ps

package kmd_pkg;

    // default matrix size
    localparam int ROWS_DEF = 6;
    localparam int COLS_DEF = 17;

    // transaction field widths
    localparam int ROW_W   = 3;
    localparam int LEVEL_W = 17;
    localparam int TDATA_W = 24;
    localparam int PAD_W   = TDATA_W - ROW_W - LEVEL_W;

    // per-key history
    localparam int HIST_W = 6;
    localparam logic [HIST_W-1:0] HIST_RESET   = 6'b111111;
    localparam logic [HIST_W-1:0] HIST_PRESS   = 6'b100000;
    localparam logic [HIST_W-1:0] HIST_RELEASE = 6'b011111;

endpackage

[hw/rtl/kmd_row_update.sv]
// per-row key history shift and press/release detection
`timescale 1ns / 1ps

module kmd_row_update #(
    parameter int COLS = kmd_pkg::COLS_DEF
) (
    input  logic [kmd_pkg::HIST_W-1:0] hist_in   [COLS],
    input  logic [COLS-1:0]            state_in,
    input  logic [COLS-1:0]            col_up,
    output logic [kmd_pkg::HIST_W-1:0] hist_out  [COLS],
    output logic [COLS-1:0]            state_out
);
    import kmd_pkg::*;

    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            hist_out[c] = {hist_in[c][HIST_W-2:0], col_up[c]};
            if (hist_out[c] == HIST_PRESS) begin
                state_out[c] = 1'b1;
            end else if (hist_out[c] == HIST_RELEASE) begin
                state_out[c] = 1'b0;
            end else begin
                state_out[c] = state_in[c];
            end
        end
    end

endmodule

[hw/rtl/key_matrix_debounce_core.sv]
// top level of the key matrix debounce block
`timescale 1ns / 1ps

// Takes one row scan per transaction (row index, raw column levels with 1 = key up) and
// returns that row's debounced pressed bits. Every key keeps a six-bit history of its
// readings; a key goes pressed after one up reading followed by five down readings and
// released after one down reading followed by five up readings. One transaction is
// accepted every cycle while the result side does not stall; its result passes from
// the input register through the history update into the result register, where it is
// presented until it is taken. A row index at or above ROWS changes nothing and returns
// zero pressed bits. Columns at or above the width of the level field read as down;
// only the low column bits reach the result.
module key_matrix_debounce_core #(
    parameter int ROWS = kmd_pkg::ROWS_DEF,
    parameter int COLS = kmd_pkg::COLS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [kmd_pkg::TDATA_W-1:0] s_tdata,  // row[2:0], col_levels[19:3], zero pad
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [kmd_pkg::TDATA_W-1:0] m_tdata   // row_res[2:0], pressed_bits[19:3], zero pad
);
    import kmd_pkg::*;

    logic               in_valid_reg;
    logic [ROW_W-1:0]   in_row_reg;
    logic [LEVEL_W-1:0] in_levels_reg;

    logic               out_valid_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [LEVEL_W-1:0] out_bits_reg;

    logic [HIST_W-1:0]  hist_reg  [ROWS][COLS];
    logic [COLS-1:0]    state_reg [ROWS];

    logic [ROWS-1:0]    row_hit;
    logic               row_ok;
    logic               advance;
    logic [HIST_W-1:0]  hist_sel  [COLS];
    logic [COLS-1:0]    state_sel;
    logic [COLS-1:0]    col_up;
    logic [HIST_W-1:0]  hist_next [COLS];
    logic [COLS-1:0]    state_next;
    logic [LEVEL_W-1:0] bits_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_bits_reg, out_row_reg};

    for (genvar r = 0; r < ROWS; r++) begin : g_hit
        assign row_hit[r] = (32'(in_row_reg) == 32'(r));
    end
    assign row_ok = |row_hit;

    always_comb begin
        hist_sel  = hist_reg[0];
        state_sel = state_reg[0];
        for (int r = 0; r < ROWS; r++) begin
            if (row_hit[r]) begin
                hist_sel  = hist_reg[r];
                state_sel = state_reg[r];
            end
        end
    end

    for (genvar c = 0; c < COLS; c++) begin : g_up
        if (c < LEVEL_W) begin : g_in
            assign col_up[c] = in_levels_reg[c];
        end else begin : g_none
            assign col_up[c] = 1'b0;
        end
    end

    kmd_row_update #(
        .COLS(COLS)
    ) u_row_update (
        .hist_in  (hist_sel),
        .state_in (state_sel),
        .col_up   (col_up),
        .hist_out (hist_next),
        .state_out(state_next)
    );

    for (genvar j = 0; j < LEVEL_W; j++) begin : g_bits
        if (j < COLS) begin : g_col
            assign bits_next[j] = state_next[j] & row_ok;
        end else begin : g_none
            assign bits_next[j] = 1'b0;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_row_reg    <= s_tdata[ROW_W-1:0];
            in_levels_reg <= s_tdata[ROW_W +: LEVEL_W];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_row_reg  <= in_row_reg;
            out_bits_reg <= bits_next;
        end
    end

    // key histories and debounced states
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                state_reg[r] <= '0;
                for (int c = 0; c < COLS; c++) begin
                    hist_reg[r][c] <= HIST_RESET;
                end
            end
        end else begin
            for (int r = 0; r < ROWS; r++) begin
                if (advance && row_hit[r]) begin
                    hist_reg[r]  <= hist_next;
                    state_reg[r] <= state_next;
                end
            end
        end
    end

endmodule

[hw/rtl/kmd_checker.sv]
// port-level checks for the key matrix debounce block, bound to the top level
`timescale 1ns / 1ps

module kmd_checker #(
    parameter int ROWS = kmd_pkg::ROWS_DEF
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [kmd_pkg::TDATA_W-1:0] s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [kmd_pkg::TDATA_W-1:0] m_tdata
);
    import kmd_pkg::*;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // an empty result register never blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

    // a new result follows an accepted transaction that passed through the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching input transaction");

    // rows outside the matrix report nothing pressed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (32'(m_tdata[ROW_W-1:0]) >= 32'(ROWS))
            |-> m_tdata[ROW_W +: LEVEL_W] == '0)
        else $error("out-of-range row reports pressed keys");

    // unused tdata bits stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[TDATA_W-1:ROW_W+LEVEL_W] == '0)
        else $error("tdata padding not zero");

endmodule

bind key_matrix_debounce_core kmd_checker #(
    .ROWS(ROWS)
) u_kmd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

[dv/tb_top.sv]
// self-checking testbench for the key matrix debounce core
`timescale 1ns / 1ps

module tb_top;

    import kmd_pkg::*;

    localparam int ROWS        = ROWS_DEF;
    localparam int COLS        = COLS_DEF;
    localparam int N_RANDOM    = 800;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_START = 400;
    localparam int QUIET_END   = 550;
    localparam int HOLD_AT     = 120;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] levels;
        logic               known;
        logic [LEVEL_W-1:0] bits;
    } scan_vec_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] bits;
    } row_state_t;

    // directed scans: row, levels (1 = up), known, typed pressed bits
    localparam int N_DIR = 24;
    localparam scan_vec_t DIR_TAB [N_DIR] = '{
        '{3'd0, 17'h1FFFF, 1'b1, 17'h00000},
        '{3'd5, 17'h1FFFF, 1'b1, 17'h00000},
        '{3'd6, 17'h00000, 1'b1, 17'h00000},
        '{3'd7, 17'h1FFFF, 1'b1, 17'h00000},
        // five down readings press every key of row 1
        '{3'd1, 17'h00000, 1'b1, 17'h00000},
        '{3'd1, 17'h00000, 1'b1, 17'h00000},
        '{3'd1, 17'h00000, 1'b1, 17'h00000},
        '{3'd1, 17'h00000, 1'b1, 17'h00000},
        '{3'd1, 17'h00000, 1'b1, 17'h1FFFF},
        // bounce, then five up readings release them
        '{3'd1, 17'h1FFFF, 1'b0, 17'h00000},
        '{3'd1, 17'h00000, 1'b0, 17'h00000},
        '{3'd1, 17'h1FFFF, 1'b0, 17'h00000},
        '{3'd1, 17'h1FFFF, 1'b0, 17'h00000},
        '{3'd1, 17'h1FFFF, 1'b0, 17'h00000},
        '{3'd1, 17'h1FFFF, 1'b0, 17'h00000},
        '{3'd1, 17'h1FFFF, 1'b0, 17'h00000},
        '{3'd0, 17'h15555, 1'b0, 17'h00000},
        '{3'd0, 17'h0AAAA, 1'b0, 17'h00000},
        '{3'd3, 17'h10000, 1'b0, 17'h00000},
        '{3'd3, 17'h10000, 1'b0, 17'h00000},
        '{3'd3, 17'h10000, 1'b0, 17'h00000},
        '{3'd3, 17'h10000, 1'b0, 17'h00000},
        '{3'd3, 17'h10000, 1'b0, 17'h00000},
        '{3'd6, 17'h1FFFF, 1'b1, 17'h00000}
    };

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    // shared pacing flags, all written with nonblocking assignments
    logic quiet       = 1'b0;
    logic hold_go     = 1'b0;
    logic hold_active = 1'b0;

    int scans_sent = 0;
    int mismatches = 0;

    row_state_t expected_rows [$];

    // debounce state mirror
    logic [HIST_W-1:0] key_hist    [ROWS][COLS];
    logic [COLS-1:0]   key_pressed [ROWS];

    key_matrix_debounce_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // shifts one row scan into the key histories, returns the row's pressed bits
    function automatic logic [LEVEL_W-1:0] debounce_row(input logic [ROW_W-1:0] r,
                                                        input logic [LEVEL_W-1:0] lv);
        logic [HIST_W-1:0] h;
        int c;
        if (r >= ROWS) return '0;
        for (c = 0; c < COLS; c++) begin
            h = {key_hist[r][c][HIST_W-2:0], lv[c]};
            key_hist[r][c] = h;
            if (h == HIST_PRESS) begin
                key_pressed[r][c] = 1'b1;
            end else if (h == HIST_RELEASE) begin
                key_pressed[r][c] = 1'b0;
            end
        end
        return key_pressed[r][LEVEL_W-1:0];
    endfunction

    task automatic offer_scan(input logic [ROW_W-1:0] r, input logic [LEVEL_W-1:0] lv,
                              input logic known, input logic [LEVEL_W-1:0] typed);
        row_state_t exp_row;
        logic [LEVEL_W-1:0] predicted;
        quiet   <= (scans_sent >= QUIET_START) && (scans_sent < QUIET_END);
        hold_go <= (scans_sent >= HOLD_AT);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, lv, r};
        do @(posedge aclk); while (!s_tready);
        predicted   = debounce_row(r, lv);
        exp_row.row  = r;
        exp_row.bits = known ? typed : predicted;
        expected_rows.push_back(exp_row);
        scans_sent++;
    endtask

    // stimulus and end of run
    initial begin
        logic [ROW_W-1:0]   r;
        logic [LEVEL_W-1:0] base;
        logic [LEVEL_W-1:0] lv;
        int reps;
        int i;
        for (i = 0; i < ROWS; i++) begin
            key_pressed[i] = '0;
            for (int c = 0; c < COLS; c++) key_hist[i][c] = HIST_RESET;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < N_DIR; i++) begin
            offer_scan(DIR_TAB[i].row, DIR_TAB[i].levels, DIR_TAB[i].known, DIR_TAB[i].bits);
        end

        // bursts of repeated scans of one row, with the odd bounced column
        while (scans_sent < N_DIR + N_RANDOM) begin
            if ($urandom_range(0, 15) == 0) begin
                r = ROW_W'($urandom_range(ROWS, 7));
            end else begin
                r = ROW_W'($urandom_range(0, ROWS - 1));
            end
            base = LEVEL_W'($urandom_range(0, 17'h1FFFF));
            reps = $urandom_range(1, 8);
            repeat (reps) begin
                lv = base;
                if ($urandom_range(0, 3) == 0) lv[$urandom_range(0, LEVEL_W - 1)] ^= 1'b1;
                offer_scan(r, lv, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_rows.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // result side: check each transaction, then pick the next ready level
    initial begin
        row_state_t exp_row;
        logic [ROW_W-1:0]   got_row;
        logic [LEVEL_W-1:0] got_bits;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got_row  = m_tdata[ROW_W-1:0];
                got_bits = m_tdata[ROW_W +: LEVEL_W];
                if (expected_rows.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: row %0d bits %05h", got_row, got_bits);
                end else begin
                    exp_row = expected_rows.pop_front();
                    if (got_row !== exp_row.row || got_bits !== exp_row.bits) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected row %0d bits %05h, got row %0d bits %05h",
                                     exp_row.row, exp_row.bits, got_row, got_bits);
                    end
                end
            end
            if (hold_active) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(0, 99) >= 8);
            end
        end
    end

    // one long back-pressure stretch so the core fills up and stalls its input
    initial begin
        do @(posedge aclk); while (!hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active <= 1'b0;
    end

    initial begin
        #(12 * 200_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
